/* design/scfp_pkg.sv */
// package for the serial command frame parser
// holds parse phase and frame kind codes, register indexes, config struct and crc step
// no dependencies
package scfp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_TILT,
    PH_ROLL,
    PH_CRC,
    PH_SERVO,
    PH_END
  } phase_t;

  typedef enum logic [1:0] {
    KIND_JOY,
    KIND_SERVO,
    KIND_HB,
    KIND_NONE
  } kind_t;

  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned ADDR_W    = 5;

  localparam logic [REG_IDX_W-1:0] REG_START     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_END       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_JOY_CODE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SERVO_CODE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HB_CODE   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CRC_POLY  = 3'd5;

  localparam logic [7:0] JOY_CENTRE    = 8'd120;
  localparam logic [7:0] CRC_POLY_INIT = 8'd7;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] joy_code;
    logic [7:0] servo_code;
    logic [7:0] hb_code;
    logic [7:0] crc_poly;
    logic       poly_load;
    logic [7:0] poly_wdata;
  } cfg_t;

  // one byte of msb-first crc-8, implicit top bit
  function automatic logic [7:0] crc8_step(input logic [7:0] crc,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* design/scfp_regs.sv */
// apb configuration registers for the frame parser
// depends on scfp_pkg
module scfp_regs
  import scfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [7:0] start_byte;
  logic [7:0] end_byte;
  logic [7:0] joy_code;
  logic [7:0] servo_code;
  logic [7:0] hb_code;
  logic [7:0] crc_poly;
  logic       wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= 8'd0;
      end_byte   <= 8'd0;
      joy_code   <= 8'd0;
      servo_code <= 8'd0;
      hb_code    <= 8'd0;
      crc_poly   <= CRC_POLY_INIT;
    end else if (wr_en) begin
      case (idx)
        REG_START:      start_byte <= pwdata[7:0];
        REG_END:        end_byte   <= pwdata[7:0];
        REG_JOY_CODE:   joy_code   <= pwdata[7:0];
        REG_SERVO_CODE: servo_code <= pwdata[7:0];
        REG_HB_CODE:    hb_code    <= pwdata[7:0];
        REG_CRC_POLY:   crc_poly   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START:      prdata = {24'd0, start_byte};
      REG_END:        prdata = {24'd0, end_byte};
      REG_JOY_CODE:   prdata = {24'd0, joy_code};
      REG_SERVO_CODE: prdata = {24'd0, servo_code};
      REG_HB_CODE:    prdata = {24'd0, hb_code};
      REG_CRC_POLY:   prdata = {24'd0, crc_poly};
      default:        prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.start_byte = start_byte;
    cfg.end_byte   = end_byte;
    cfg.joy_code   = joy_code;
    cfg.servo_code = servo_code;
    cfg.hb_code    = hb_code;
    cfg.crc_poly   = crc_poly;
    cfg.poly_load  = wr_en && (idx == REG_CRC_POLY);
    cfg.poly_wdata = pwdata[7:0];
  end

endmodule

/* design/scfp_parse.sv */
// frame parser datapath: input register, phase state machine, result register
// depends on scfp_pkg; its cfg input is driven by scfp_regs at the top level
module scfp_parse
  import scfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] frame_kind,
  output logic [7:0] tilt_value,
  output logic [7:0] roll_value,
  output logic       servo_on
);

  // input register
  logic       in_full;
  logic [7:0] in_data;
  logic       accept;
  logic       advance;

  // parser state
  phase_t     phase, phase_next;
  kind_t      kind, kind_next;
  logic [7:0] held_tilt;
  logic [7:0] held_roll;
  logic       held_enable;
  logic [7:0] crc_tilt;   // crc over the tilt byte alone
  logic [7:0] crc_full;
  logic       emit;

  assign accept   = in_valid && !in_stall;
  assign advance  = in_full && (!emit || !out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign crc_full = crc8_step(crc_tilt, held_roll, cfg.crc_poly);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_data <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      kind  <= KIND_NONE;
    end else if (advance) begin
      phase <= phase_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    phase_next = PH_IDLE;
    kind_next  = kind;
    emit       = 1'b0;
    case (phase)
      PH_IDLE: begin
        phase_next = (in_data == cfg.start_byte) ? PH_TYPE : PH_IDLE;
      end
      PH_TYPE: begin
        // joystick code wins over servo, servo over heartbeat
        if (in_data == cfg.joy_code) begin
          phase_next = PH_TILT;
          kind_next  = KIND_JOY;
        end else if (in_data == cfg.servo_code) begin
          phase_next = PH_SERVO;
          kind_next  = KIND_SERVO;
        end else if (in_data == cfg.hb_code) begin
          phase_next = PH_END;
          kind_next  = KIND_HB;
        end else begin
          kind_next  = KIND_NONE;
        end
      end
      PH_TILT:  phase_next = PH_ROLL;
      PH_ROLL:  phase_next = PH_CRC;
      PH_CRC: begin
        if (crc_full == in_data) begin
          phase_next = PH_END;
        end else begin
          kind_next  = KIND_NONE;
        end
      end
      PH_SERVO: phase_next = PH_END;
      PH_END: begin
        emit      = in_full && (in_data == cfg.end_byte) && (kind != KIND_NONE);
        kind_next = KIND_NONE;
      end
      default: begin
        kind_next = KIND_NONE;
      end
    endcase
  end

  // held bytes; a write with no advance redoes the tilt crc with the new poly
  always_ff @(posedge clk) begin
    if (rst) begin
      held_tilt   <= JOY_CENTRE;
      held_roll   <= JOY_CENTRE;
      held_enable <= 1'b0;
      crc_tilt    <= crc8_step(8'd0, JOY_CENTRE, CRC_POLY_INIT);
    end else if (advance) begin
      if (phase == PH_TILT) begin
        held_tilt <= in_data;
        crc_tilt  <= crc8_step(8'd0, in_data, cfg.crc_poly);
      end
      if (phase == PH_ROLL) begin
        held_roll <= in_data;
      end
      if (phase == PH_SERVO) begin
        held_enable <= (in_data != 8'd0);
      end
    end else if (cfg.poly_load) begin
      crc_tilt <= crc8_step(8'd0, held_tilt, cfg.poly_wdata);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      frame_kind <= kind;
      tilt_value <= (kind == KIND_JOY) ? held_tilt : 8'd0;
      roll_value <= (kind == KIND_JOY) ? held_roll : 8'd0;
      servo_on   <= (kind == KIND_SERVO) ? held_enable : 1'b0;
    end
  end

endmodule

/* design/serial_command_frame_parser.sv */
// top level of the serial command frame parser
// depends on scfp_pkg, scfp_regs and scfp_parse
//
//  channel   valid      stall      payload
//  input     in_valid   in_stall   rx_byte
//  output    out_valid  out_stall  frame_kind, tilt_value, roll_value, servo_on
//  config    apb write/read, psel/penable/pwrite/paddr/pwdata/prdata/pready
//
// one byte is taken every cycle while in_stall is low, then parsed from the
// input register; a frame result shows the cycle after its end byte is parsed
// bytes that give no result never wait on the output side
// a held result stalls parsing only when the next byte also completes a frame
// rst is synchronous and returns the parser to idle with default registers
module serial_command_frame_parser
  import scfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        frame_kind,
  output logic [7:0]        tilt_value,
  output logic [7:0]        roll_value,
  output logic              servo_on
);

  cfg_t cfg;

  scfp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scfp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_kind (frame_kind),
    .tilt_value (tilt_value),
    .roll_value (roll_value),
    .servo_on   (servo_on)
  );

endmodule

/* design/scfp_checker.sv */
// port-level checks for the serial command frame parser, bound to the top level
// depends on scfp_pkg
module scfp_checker
  import scfp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] frame_kind,
  input logic [7:0] tilt_value,
  input logic [7:0] roll_value,
  input logic       servo_on
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_kind)
      && $stable(tilt_value) && $stable(roll_value) && $stable(servo_on))
    else $error("stalled result changed");

  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_kind != KIND_NONE)
    else $error("result with no frame kind");

  a_joy_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind != KIND_JOY |-> tilt_value == 8'd0 && roll_value == 8'd0)
    else $error("tilt or roll set on non-joystick result");

  a_servo_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind != KIND_SERVO |-> !servo_on)
    else $error("servo_on set on non-servo result");

endmodule

bind serial_command_frame_parser scfp_checker u_scfp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .frame_kind (frame_kind),
  .tilt_value (tilt_value),
  .roll_value (roll_value),
  .servo_on   (servo_on)
);
